FILE: hw/rtl/psrc_pkg.sv
`default_nettype none

package psrc_pkg;

    // Sizes
    localparam int unsigned PORT_SLOTS_DEF = 1024;
    localparam int unsigned QUEUE_DEPTH    = 4;
    localparam int unsigned QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned COUNT_W        = 11;
    localparam int unsigned CFG_DATA_W     = 11;

    typedef logic [2:0]          t_scan;
    typedef logic [COUNT_W-1:0]  t_count;
    typedef logic [6:0]          t_pos;
    typedef logic [1:0]          t_action;
    typedef logic [1:0]          t_pstate;

    // Configuration register indexes
    localparam logic CFG_SCAN_TYPE  = 1'b0;
    localparam logic CFG_PORT_COUNT = 1'b1;

    // Request types
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_BYTE = 1'b1;

    // Scan types
    localparam t_scan SCAN_SYN  = 3'd0;
    localparam t_scan SCAN_NULL = 3'd1;
    localparam t_scan SCAN_ACK  = 3'd2;
    localparam t_scan SCAN_FIN  = 3'd3;
    localparam t_scan SCAN_XMAS = 3'd4;
    localparam t_scan SCAN_UDP  = 3'd5;

    // Frame byte offsets: cooked header, IPv4 header, transport header
    localparam t_pos POS_PROTO     = 7'd25;
    localparam t_pos POS_SPORT_HI  = 7'd36;
    localparam t_pos POS_SPORT_LO  = 7'd37;
    localparam t_pos POS_ICMP_CODE = 7'd37;
    localparam t_pos POS_FLAGS     = 7'd49;
    localparam t_pos POS_IDPORT_HI = 7'd66;
    localparam t_pos POS_IDPORT_LO = 7'd67;
    localparam t_pos POS_MAX       = 7'd127;

    // IP protocol numbers and header values
    localparam logic [7:0] PROTO_ICMP        = 8'd1;
    localparam logic [7:0] PROTO_TCP         = 8'd6;
    localparam logic [7:0] PROTO_UDP         = 8'd17;
    localparam logic [7:0] FLAG_RST          = 8'h04;
    localparam logic [7:0] FLAG_SYNACK       = 8'h12;
    localparam logic [7:0] CODE_PORT_UNREACH = 8'd3;

    // Result codes
    localparam t_action ACT_NONE  = 2'd0;
    localparam t_action ACT_PORT  = 2'd1;
    localparam t_action ACT_STATE = 2'd2;

    localparam t_pstate PS_OPEN     = 2'd0;
    localparam t_pstate PS_CLOSED   = 2'd1;
    localparam t_pstate PS_FILTERED = 2'd2;

    // Work passed from the parser to the table search
    typedef struct packed {
        logic        is_frame;
        logic        have;
        t_action     act;
        t_pstate     st;
        logic [15:0] port;
        logic [9:0]  idx;
    } t_job;

endpackage

`default_nettype wire

FILE: hw/rtl/port_scan_reply_classifier.sv
`default_nettype none

// Port scan reply classifier. Load the port table with req_type 0 items (one slot
// each), set scan_type and port_count, then stream captured reply frames one byte
// per transaction with last_byte on the final byte. Each frame's last byte yields
// exactly one result; loads yield none. Input transactions are taken one per cycle
// as long as the four-entry job queue behind the byte parser has room. Each job is
// then run by the table search: a load writes its slot if the index is below
// PORT_SLOTS, a frame whose reply is not classified goes to the output without a
// search, and a classified frame reads up to min(port_count, PORT_SLOTS) entries,
// one table entry per cycle from a single-port RAM, stopping at the first match.
// Results wait in a one-deep output register while the next job runs. The table
// needs no clearing after reset; searching slots that were never loaded gives
// undefined results.
module port_scan_reply_classifier #(
    parameter int unsigned PORT_SLOTS = psrc_pkg::PORT_SLOTS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Input queue side
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic                               i_req_type,
    input  wire logic [9:0]                         i_entry_index,
    input  wire logic [15:0]                        i_port_value,
    input  wire logic [7:0]                         i_data_byte,
    input  wire logic                               i_last_byte,
    // Result queue side
    output logic                                    empty,
    input  wire logic                               pop,
    output logic [1:0]                              o_action,
    output logic                                    o_port_found,
    output logic [9:0]                              o_port_index,
    output logic [15:0]                             o_port_number,
    output logic [1:0]                              o_port_state,
    // Configuration writes
    input  wire logic                               i_cfg_we,
    input  wire logic                               i_cfg_idx,
    input  wire logic [psrc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    psrc_pkg::t_scan    r_scan_type;
    psrc_pkg::t_count   r_port_count;

    logic               w_take;
    logic               w_job_valid;
    psrc_pkg::t_job     w_job;
    psrc_pkg::t_job     w_head;
    logic               w_head_empty;
    logic               w_head_pop;

    assign w_take = push && !full;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_type  <= psrc_pkg::SCAN_SYN;
            r_port_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                psrc_pkg::CFG_SCAN_TYPE: begin
                    r_scan_type <= i_cfg_data[2:0];
                end
                psrc_pkg::CFG_PORT_COUNT: begin
                    r_port_count <= i_cfg_data;
                end
                default: begin
                    r_port_count <= r_port_count;
                end
            endcase
        end
    end

    // Parse bytes and classify replies
    psrc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (w_take),
        .i_req_type    (i_req_type),
        .i_entry_index (i_entry_index),
        .i_port_value  (i_port_value),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .i_scan_type   (r_scan_type),
        .o_job_valid   (w_job_valid),
        .o_job         (w_job)
    );

    // Decouple parser from table search
    psrc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_valid),
        .i_job   (w_job),
        .o_full  (full),
        .i_pop   (w_head_pop),
        .o_job   (w_head),
        .o_empty (w_head_empty)
    );

    // Own the port table, search it and deliver results
    psrc_back #(
        .PORT_SLOTS (PORT_SLOTS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (w_head),
        .i_job_empty   (w_head_empty),
        .o_job_pop     (w_head_pop),
        .i_port_count  (r_port_count),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_action      (o_action),
        .o_port_found  (o_port_found),
        .o_port_index  (o_port_index),
        .o_port_number (o_port_number),
        .o_port_state  (o_port_state)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/psrc_front.sv
`default_nettype none

module psrc_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_take,
    input  wire logic               i_req_type,
    input  wire logic [9:0]         i_entry_index,
    input  wire logic [15:0]        i_port_value,
    input  wire logic [7:0]         i_data_byte,
    input  wire logic               i_last_byte,
    input  wire psrc_pkg::t_scan    i_scan_type,
    output logic                    o_job_valid,
    output psrc_pkg::t_job          o_job
);

    psrc_pkg::t_pos r_pos;
    logic [7:0]     r_proto;
    logic [15:0]    r_sport;
    logic [7:0]     r_flags;
    logic [7:0]     r_code;
    logic [15:0]    r_idport;

    logic [7:0]     n_proto;
    logic [15:0]    n_sport;
    logic [7:0]     n_flags;
    logic [7:0]     n_code;
    logic [15:0]    n_idport;
    psrc_pkg::t_pos n_pos;

    logic             w_byte;
    logic             w_tcp;
    logic             w_udp;
    logic             w_icmp;
    logic             w_rst;
    logic             w_have;
    psrc_pkg::t_action w_act;
    psrc_pkg::t_pstate w_st;
    logic [15:0]      w_port;

    assign w_byte = i_take && (i_req_type == psrc_pkg::REQ_BYTE);

    // Latch header fields at their offsets, including the current byte
    always_comb begin
        n_proto = (r_pos == psrc_pkg::POS_PROTO) ? i_data_byte : r_proto;
        n_sport[15:8] = (r_pos == psrc_pkg::POS_SPORT_HI) ? i_data_byte : r_sport[15:8];
        n_sport[7:0]  = (r_pos == psrc_pkg::POS_SPORT_LO) ? i_data_byte : r_sport[7:0];
        n_code  = (r_pos == psrc_pkg::POS_ICMP_CODE) ? i_data_byte : r_code;
        n_flags = (r_pos == psrc_pkg::POS_FLAGS) ? i_data_byte : r_flags;
        n_idport[15:8] = (r_pos == psrc_pkg::POS_IDPORT_HI) ? i_data_byte : r_idport[15:8];
        n_idport[7:0]  = (r_pos == psrc_pkg::POS_IDPORT_LO) ? i_data_byte : r_idport[7:0];
        if (i_last_byte) begin
            n_pos = '0;
        end else if (r_pos != psrc_pkg::POS_MAX) begin
            n_pos = r_pos + 7'd1;
        end else begin
            n_pos = r_pos;
        end
    end

    // Frame long enough for the fields that its rule reads
    assign w_tcp  = (n_proto == psrc_pkg::PROTO_TCP)  && (r_pos >= psrc_pkg::POS_FLAGS);
    assign w_udp  = (n_proto == psrc_pkg::PROTO_UDP)  && (r_pos >= psrc_pkg::POS_SPORT_LO);
    assign w_icmp = (n_proto == psrc_pkg::PROTO_ICMP) && (r_pos >= psrc_pkg::POS_IDPORT_LO);
    assign w_rst  = (n_flags & psrc_pkg::FLAG_RST) != 8'd0;

    // Classify the reply for the configured scan type
    always_comb begin
        w_have = 1'b0;
        w_act  = psrc_pkg::ACT_NONE;
        w_st   = psrc_pkg::PS_OPEN;
        w_port = '0;
        case (i_scan_type)
            psrc_pkg::SCAN_SYN: begin
                if (w_tcp) begin
                    w_have = 1'b1;
                    w_port = n_sport;
                    w_act  = psrc_pkg::ACT_PORT;
                    if (n_flags == psrc_pkg::FLAG_SYNACK) begin
                        w_act = psrc_pkg::ACT_STATE;
                        w_st  = psrc_pkg::PS_OPEN;
                    end else if (w_rst) begin
                        w_act = psrc_pkg::ACT_STATE;
                        w_st  = psrc_pkg::PS_CLOSED;
                    end
                end
            end
            psrc_pkg::SCAN_NULL, psrc_pkg::SCAN_FIN, psrc_pkg::SCAN_XMAS: begin
                if (w_tcp) begin
                    w_have = 1'b1;
                    w_port = n_sport;
                    w_act  = psrc_pkg::ACT_PORT;
                    if (w_rst) begin
                        w_act = psrc_pkg::ACT_STATE;
                        w_st  = psrc_pkg::PS_CLOSED;
                    end
                end else if (w_icmp) begin
                    w_have = 1'b1;
                    w_port = n_idport;
                    w_act  = psrc_pkg::ACT_STATE;
                    w_st   = psrc_pkg::PS_FILTERED;
                end
            end
            psrc_pkg::SCAN_ACK: begin
                if (w_tcp) begin
                    w_have = 1'b1;
                    w_port = n_sport;
                    w_act  = psrc_pkg::ACT_PORT;
                    if (w_rst) begin
                        w_act = psrc_pkg::ACT_STATE;
                        w_st  = psrc_pkg::PS_CLOSED;
                    end
                end
            end
            psrc_pkg::SCAN_UDP: begin
                if (w_udp) begin
                    w_have = 1'b1;
                    w_port = n_sport;
                    w_act  = psrc_pkg::ACT_STATE;
                    w_st   = psrc_pkg::PS_OPEN;
                end else if (w_icmp) begin
                    w_have = 1'b1;
                    w_port = n_idport;
                    w_act  = psrc_pkg::ACT_STATE;
                    w_st   = (n_code == psrc_pkg::CODE_PORT_UNREACH) ?
                             psrc_pkg::PS_CLOSED : psrc_pkg::PS_FILTERED;
                end
            end
            default: begin
                w_have = 1'b0;
            end
        endcase
    end

    // Build the job: a table load, or a finished frame
    always_comb begin
        o_job_valid   = i_take && ((i_req_type == psrc_pkg::REQ_LOAD) || i_last_byte);
        o_job.is_frame = (i_req_type == psrc_pkg::REQ_BYTE);
        o_job.have    = w_have;
        o_job.act     = w_act;
        o_job.st      = w_st;
        o_job.port    = (i_req_type == psrc_pkg::REQ_BYTE) ? w_port : i_port_value;
        o_job.idx     = i_entry_index;
    end

    // Hold parser state between bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_proto  <= '0;
            r_sport  <= '0;
            r_flags  <= '0;
            r_code   <= '0;
            r_idport <= '0;
        end else if (w_byte) begin
            r_pos    <= n_pos;
            r_proto  <= n_proto;
            r_sport  <= n_sport;
            r_flags  <= n_flags;
            r_code   <= n_code;
            r_idport <= n_idport;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/psrc_queue.sv
`default_nettype none

module psrc_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire psrc_pkg::t_job  i_job,
    output logic                 o_full,
    input  wire logic            i_pop,
    output psrc_pkg::t_job       o_job,
    output logic                 o_empty
);

    psrc_pkg::t_job                 r_slot [psrc_pkg::QUEUE_DEPTH];
    logic [psrc_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [psrc_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [psrc_pkg::QCNT_W-1:0]    r_count;

    logic w_do_push;
    logic w_do_pop;

    assign o_full    = (r_count == psrc_pkg::QCNT_W'(psrc_pkg::QUEUE_DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_job     = r_slot[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // Store the entry
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= psrc_pkg::QCNT_W'(psrc_pkg::QUEUE_DEPTH))
        else $error("queue count above depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_do_push && !w_do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not grow on push");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/psrc_back.sv
`default_nettype none

module psrc_back #(
    parameter int unsigned PORT_SLOTS = psrc_pkg::PORT_SLOTS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire psrc_pkg::t_job     i_job,
    input  wire logic               i_job_empty,
    output logic                    o_job_pop,
    input  wire psrc_pkg::t_count   i_port_count,
    output logic                    o_empty,
    input  wire logic               i_pop,
    output psrc_pkg::t_action       o_action,
    output logic                    o_port_found,
    output logic [9:0]              o_port_index,
    output logic [15:0]             o_port_number,
    output psrc_pkg::t_pstate       o_port_state
);

    localparam int unsigned AW = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_EMIT
    } t_state;

    t_state             r_state;

    // Port table
    logic [15:0]        r_table [PORT_SLOTS];
    logic [15:0]        r_rdata;

    // Current search
    logic [15:0]        r_port;
    psrc_pkg::t_action  r_act;
    psrc_pkg::t_pstate  r_st;
    psrc_pkg::t_count   r_limit;
    psrc_pkg::t_count   r_issue;
    psrc_pkg::t_count   r_cmp_idx;
    logic               r_cmp_valid;

    // Finished result and output slot
    psrc_pkg::t_action  r_res_act;
    logic               r_res_found;
    logic [9:0]         r_res_idx;
    logic [15:0]        r_res_port;
    psrc_pkg::t_pstate  r_res_st;
    logic               r_out_valid;
    psrc_pkg::t_action  r_out_act;
    logic               r_out_found;
    logic [9:0]         r_out_idx;
    logic [15:0]        r_out_port;
    psrc_pkg::t_pstate  r_out_st;

    logic                       w_we;
    logic [AW+9:0]              w_waddr_ext;
    logic [AW+psrc_pkg::COUNT_W-1:0] w_raddr_ext;
    logic [AW-1:0]              w_waddr;
    logic [AW-1:0]              w_raddr;
    psrc_pkg::t_count           w_limit;
    logic                       w_issue;
    logic                       w_hit;
    logic                       w_out_free;

    assign o_job_pop   = (r_state == S_IDLE) && !i_job_empty;
    assign w_we        = o_job_pop && !i_job.is_frame && (32'(i_job.idx) < PORT_SLOTS);
    assign w_waddr_ext = {{AW{1'b0}}, i_job.idx};
    assign w_waddr     = w_waddr_ext[AW-1:0];
    assign w_raddr_ext = {{AW{1'b0}}, r_issue};
    assign w_raddr     = w_raddr_ext[AW-1:0];
    assign w_limit     = (32'(i_port_count) < PORT_SLOTS) ?
                         i_port_count : psrc_pkg::t_count'(PORT_SLOTS);
    assign w_issue     = (r_state == S_SEARCH) && (r_issue < r_limit);
    assign w_hit       = r_cmp_valid && (r_rdata == r_port);
    assign w_out_free  = !r_out_valid || i_pop;

    // Write loads, read one entry per cycle during a search
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_table[w_waddr] <= i_job.port;
        end
        if (w_issue) begin
            r_rdata <= r_table[w_raddr];
        end
    end

    // Sequence jobs: search the table, then hand the result to the output slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmp_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_pop) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_job_empty && i_job.is_frame) begin
                        r_port <= i_job.port;
                        r_act  <= i_job.act;
                        r_st   <= i_job.st;
                        if (i_job.have) begin
                            r_issue     <= '0;
                            r_cmp_valid <= 1'b0;
                            r_limit     <= w_limit;
                            r_state     <= S_SEARCH;
                        end else begin
                            r_res_act   <= psrc_pkg::ACT_NONE;
                            r_res_found <= 1'b0;
                            r_res_idx   <= '0;
                            r_res_port  <= '0;
                            r_res_st    <= psrc_pkg::PS_OPEN;
                            r_state     <= S_EMIT;
                        end
                    end
                end
                S_SEARCH: begin
                    r_cmp_valid <= w_issue;
                    r_cmp_idx   <= r_issue;
                    if (w_issue) begin
                        r_issue <= r_issue + psrc_pkg::t_count'(1);
                    end
                    if (w_hit) begin
                        r_res_act   <= r_act;
                        r_res_found <= 1'b1;
                        r_res_idx   <= r_cmp_idx[9:0];
                        r_res_port  <= r_port;
                        r_res_st    <= r_st;
                        r_state     <= S_EMIT;
                    end else if (!r_cmp_valid && !w_issue) begin
                        // Port not in the table: no update
                        r_res_act   <= psrc_pkg::ACT_NONE;
                        r_res_found <= 1'b0;
                        r_res_idx   <= '0;
                        r_res_port  <= r_port;
                        r_res_st    <= psrc_pkg::PS_OPEN;
                        r_state     <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_act   <= r_res_act;
                        r_out_found <= r_res_found;
                        r_out_idx   <= r_res_idx;
                        r_out_port  <= r_res_port;
                        r_out_st    <= r_res_st;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_action      = r_out_act;
    assign o_port_found  = r_out_found;
    assign o_port_index  = r_out_idx;
    assign o_port_number = r_out_port;
    assign o_port_state  = r_out_st;

`ifndef ASSERT_OFF
    a_miss_no_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_port_found) |-> (o_action == psrc_pkg::ACT_NONE))
        else $error("action given for a port not in the table");

    a_state_needs_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && (o_action != psrc_pkg::ACT_STATE)) |-> (o_port_state == psrc_pkg::PS_OPEN))
        else $error("port state set without a state action");

    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_issue <= r_limit))
        else $error("table search ran past its limit");
`endif

endmodule

`default_nettype wire
